>>> rtl/hd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_pkg
// Shared types and constants for the haversine distance pipeline.
// ----------------------------------------------------------------------------
package hd_pkg;

   // cordic datapath width, signed
   localparam int CW = 34;
   // square root cell widths: remainder and root
   localparam int RW = 61;
   localparam int QW = 31;

   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 31;

   localparam logic [25:0] TURN_Q17    = 26'd47185920;
   localparam logic [25:0] QUARTER_Q17 = 26'd11796480;
   localparam logic [26:0] DEG_TO_RAD  = 27'd74961321;
   localparam logic signed [CW-1:0] INV_GAIN   = 34'sd652032874;
   localparam logic signed [CW-1:0] HALF_PI    = 34'sd1686629713;
   localparam logic [29:0]          DIST_SCALE = 30'd835061023;
   localparam logic [30:0]          ONE_Q30    = 31'd1073741824;
   localparam logic [RW-1:0]        ONE_Q60    = 61'd1 << 60;

   localparam logic signed [CW-1:0] ATAN_TAB [10] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149
   };

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } hd_vec_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [QW-1:0] root;
   } hd_sqrt_type;

   function automatic logic signed [CW-1:0] step_angle(input int i);
      logic signed [CW-1:0] a;
      if (i < 10) begin
         a = ATAN_TAB[i];
      end else begin
         a = CW'(1) <<< (30 - i);
      end
      return a;
   endfunction

endpackage

>>> rtl/hd_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_cordic_cell
// One registered cordic micro-rotation, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module hd_cordic_cell #(
   parameter int STEP   = 0,
   parameter bit VECTOR = 1'b0
) (
   input  logic               clock,
   input  logic               en,
   input  hd_pkg::hd_vec_type prev_vec,
   output hd_pkg::hd_vec_type next_vec
);
   import hd_pkg::*;

   localparam logic signed [CW-1:0] ANGLE = step_angle(STEP);

   logic signed [CW-1:0] x, y, z, dx, dy;
   logic                 pos;
   hd_vec_type           vec_ff, vec_in;

   always_comb begin
      x   = prev_vec.x;
      y   = prev_vec.y;
      z   = prev_vec.z;
      dx  = y >>> STEP;
      dy  = x >>> STEP;
      pos = VECTOR ? !(y > 0) : !z[CW-1];
      if (pos) begin
         vec_in.x = x - dx;
         vec_in.y = y + dy;
         vec_in.z = z - ANGLE;
      end else begin
         vec_in.x = x + dx;
         vec_in.y = y - dy;
         vec_in.z = z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign next_vec = vec_ff;

endmodule

>>> rtl/hd_isqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_isqrt_cell
// One registered digit of a restoring integer square root.
// ----------------------------------------------------------------------------
module hd_isqrt_cell #(
   parameter int J = 0
) (
   input  logic                clock,
   input  logic                en,
   input  hd_pkg::hd_sqrt_type prev_sq,
   output hd_pkg::hd_sqrt_type next_sq
);
   import hd_pkg::*;

   logic [RW+1:0] cand;
   hd_sqrt_type   sq_ff, sq_in;

   always_comb begin
      cand = ((RW+2)'(prev_sq.root) << (J + 1)) + ((RW+2)'(1) << (2 * J));
      if ((RW+2)'(prev_sq.rem) >= cand) begin
         sq_in.rem  = prev_sq.rem - cand[RW-1:0];
         sq_in.root = prev_sq.root | (QW'(1) << J);
      end else begin
         sq_in = prev_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
      end
   end

   assign next_sq = sq_ff;

endmodule

>>> rtl/haversine_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance of a point pair, pipelined cordic and square roots.
//
//   channel   ports                                   direction
//   req       req_valid/ready, lat_a lon_a lat_b lon_b in
//   rsp       rsp_valid/ready, distance (1/256 km)     out
//
// One transaction per cycle while the rsp channel does not stall the pipe.
// The pipe's depth is set mostly by two 30-cell cordic chains and a 31-cell square root.
// Reset clears the valid bits only; data registers carry no reset.
// A stalled result holds the pipe only when its last stage holds a transaction.
// ----------------------------------------------------------------------------
module haversine_distance (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_lat_a,
   input  logic signed [24:0] req_lon_a,
   input  logic signed [23:0] req_lat_b,
   input  logic signed [24:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [22:0] rsp_distance
);
   import hd_pkg::*;

   localparam int ST_ROT  = 4;
   localparam int ST_CS   = ST_ROT + CORDIC_STEPS;
   localparam int ST_MUL  = ST_CS + 1;
   localparam int ST_UV   = ST_MUL + 1;
   localparam int ST_T2   = ST_UV + 1;
   localparam int ST_H    = ST_T2 + 1;
   localparam int ST_HC   = ST_H + 1;
   localparam int ST_SQ   = ST_HC + SQRT_STEPS;
   localparam int ST_VEC  = ST_SQ + CORDIC_STEPS;
   localparam int ST_DP   = ST_VEC + 1;
   localparam int QD      = ST_CS - 3;

   logic                   en;
   logic                   vld_ff [0:ST_DP];
   logic                   rsp_valid_ff;
   logic [22:0]            rsp_distance_ff;

   logic signed [25:0]     ang_ff  [4];
   logic signed [25:0]     ang_in  [4];
   logic        [25:0]     turn_ff [4];
   logic        [25:0]     turn_in [4];
   logic        [23:0]     r_ff    [4];
   logic        [23:0]     r_in    [4];
   logic        [1:0]      q_in    [4];
   logic        [7:0]      qd_ff   [0:QD];
   logic        [50:0]     prod_ff [4];
   logic        [50:0]     rnd     [4];

   hd_vec_type             rot_vec [4][0:CORDIC_STEPS];

   logic        [30:0]     cx [4], cy [4];
   logic        [1:0]      qf [4];
   logic        [30:0]     mag_s_ff [2];
   logic        [30:0]     mag_c_ff [2];
   logic                   neg_c_ff [2];

   logic        [61:0]     t1_ff, pu_ff, pv_ff, t1b_ff, t2_ff;
   logic        [61:0]     t1c_ff;
   logic        [30:0]     u_ff, v_ff;
   logic                   neg_ff, negb_ff, negc_ff;
   logic        [61:0]     pu_r, pv_r;
   logic signed [63:0]     hs;
   logic        [RW-1:0]   h_ff, h_in, hb_ff, hc_ff;

   hd_sqrt_type            sqy [0:SQRT_STEPS];
   hd_sqrt_type            sqx [0:SQRT_STEPS];
   hd_vec_type             vec [0:CORDIC_STEPS];

   logic signed [CW-1:0]   zf;
   logic        [30:0]     zc;
   logic        [60:0]     dp_ff;
   logic        [60:0]     dp_r;

   assign en        = !rsp_valid_ff || rsp_ready || !vld_ff[ST_DP];
   assign req_ready = en;

   // front end: half angles, turn reduction, quadrant split
   always_comb begin
      ang_in[0] = 26'(req_lat_b) - 26'(req_lat_a);
      ang_in[1] = 26'(req_lon_b) - 26'(req_lon_a);
      ang_in[2] = 26'($signed({req_lat_a, 1'b0}));
      ang_in[3] = 26'($signed({req_lat_b, 1'b0}));
      for (int k = 0; k < 4; k++) begin
         turn_in[k] = ang_ff[k][25] ? 26'(27'(ang_ff[k]) + 27'(TURN_Q17))
                                    : 26'(ang_ff[k]);
         if (turn_ff[k] >= 26'(3 * QUARTER_Q17)) begin
            q_in[k] = 2'd3;
            r_in[k] = 24'(turn_ff[k] - 26'(3 * QUARTER_Q17));
         end else if (turn_ff[k] >= 26'(2 * QUARTER_Q17)) begin
            q_in[k] = 2'd2;
            r_in[k] = 24'(turn_ff[k] - 26'(2 * QUARTER_Q17));
         end else if (turn_ff[k] >= QUARTER_Q17) begin
            q_in[k] = 2'd1;
            r_in[k] = 24'(turn_ff[k] - QUARTER_Q17);
         end else begin
            q_in[k] = 2'd0;
            r_in[k] = turn_ff[k][23:0];
         end
         rnd[k] = (prod_ff[k] + 51'(1 << 18)) >> 19;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            ang_ff[k]  <= ang_in[k];
            turn_ff[k] <= turn_in[k];
            r_ff[k]    <= r_in[k];
            prod_ff[k] <= 51'(r_ff[k]) * 51'(DEG_TO_RAD);
         end
         qd_ff[0] <= {q_in[3], q_in[2], q_in[1], q_in[0]};
         for (int k = 1; k <= QD; k++) begin
            qd_ff[k] <= qd_ff[k-1];
         end
      end
   end

   // four rotation chains: dlat/2, dlon/2, lat_a, lat_b
   for (genvar k = 0; k < 4; k++) begin : g_rot
      assign rot_vec[k][0].x = INV_GAIN;
      assign rot_vec[k][0].y = '0;
      assign rot_vec[k][0].z = CW'(rnd[k]);
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
         hd_cordic_cell #(.STEP(i), .VECTOR(1'b0)) u_cell (
            .clock    (clock),
            .en       (en),
            .prev_vec (rot_vec[k][i]),
            .next_vec (rot_vec[k][i+1])
         );
      end
   end

   // clamp and quadrant fold into magnitude and sign
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         qf[k] = qd_ff[QD][2*k +: 2];
         if (rot_vec[k][CORDIC_STEPS].x < 0) begin
            cx[k] = '0;
         end else if (rot_vec[k][CORDIC_STEPS].x > $signed(CW'(ONE_Q30))) begin
            cx[k] = ONE_Q30;
         end else begin
            cx[k] = rot_vec[k][CORDIC_STEPS].x[30:0];
         end
         if (rot_vec[k][CORDIC_STEPS].y < 0) begin
            cy[k] = '0;
         end else if (rot_vec[k][CORDIC_STEPS].y > $signed(CW'(ONE_Q30))) begin
            cy[k] = ONE_Q30;
         end else begin
            cy[k] = rot_vec[k][CORDIC_STEPS].y[30:0];
         end
      end
   end

   assign pu_r = (pu_ff + 62'(1 << 29)) >> 30;
   assign pv_r = (pv_ff + 62'(1 << 29)) >> 30;
   assign hs   = negc_ff ? $signed(64'(t1c_ff)) - $signed(64'(t2_ff))
                         : $signed(64'(t1c_ff)) + $signed(64'(t2_ff));

   always_comb begin
      if (hs < 0) begin
         h_in = '0;
      end else if (hs > $signed(64'(ONE_Q60))) begin
         h_in = ONE_Q60;
      end else begin
         h_in = hs[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 2; k++) begin
            mag_s_ff[k] <= qf[k][0] ? cx[k] : cy[k];
            mag_c_ff[k] <= qf[k+2][0] ? cy[k+2] : cx[k+2];
            neg_c_ff[k] <= (qf[k+2] == 2'd1 || qf[k+2] == 2'd2) &&
                           ((qf[k+2][0] ? cy[k+2] : cx[k+2]) != '0);
         end
         t1_ff   <= 62'(mag_s_ff[0]) * 62'(mag_s_ff[0]);
         pu_ff   <= 62'(mag_c_ff[0]) * 62'(mag_s_ff[1]);
         pv_ff   <= 62'(mag_c_ff[1]) * 62'(mag_s_ff[1]);
         neg_ff  <= neg_c_ff[0] != neg_c_ff[1];
         u_ff    <= pu_r[30:0];
         v_ff    <= pv_r[30:0];
         t1b_ff  <= t1_ff;
         negb_ff <= neg_ff;
         t2_ff   <= 62'(u_ff) * 62'(v_ff);
         t1c_ff  <= t1b_ff;
         negc_ff <= negb_ff;
         h_ff    <= h_in;
         hb_ff   <= h_ff;
         hc_ff   <= ONE_Q60 - h_ff;
      end
   end

   // square roots of h and 1-h
   assign sqy[0].rem  = hb_ff;
   assign sqy[0].root = '0;
   assign sqx[0].rem  = hc_ff;
   assign sqx[0].root = '0;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sq
      hd_isqrt_cell #(.J(SQRT_STEPS - 1 - j)) u_sqy (
         .clock   (clock),
         .en      (en),
         .prev_sq (sqy[j]),
         .next_sq (sqy[j+1])
      );
      hd_isqrt_cell #(.J(SQRT_STEPS - 1 - j)) u_sqx (
         .clock   (clock),
         .en      (en),
         .prev_sq (sqx[j]),
         .next_sq (sqx[j+1])
      );
   end

   // vectoring chain for atan2
   assign vec[0].x = CW'(sqx[SQRT_STEPS].root);
   assign vec[0].y = CW'(sqy[SQRT_STEPS].root);
   assign vec[0].z = '0;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      hd_cordic_cell #(.STEP(i), .VECTOR(1'b1)) u_cell (
         .clock    (clock),
         .en       (en),
         .prev_vec (vec[i]),
         .next_vec (vec[i+1])
      );
   end

   always_comb begin
      zf = vec[CORDIC_STEPS].z;
      if (zf < 0) begin
         zc = '0;
      end else if (zf > HALF_PI) begin
         zc = HALF_PI[30:0];
      end else begin
         zc = zf[30:0];
      end
   end

   assign dp_r = (dp_ff + 61'(64'd1 << 37)) >> 38;

   always_ff @(posedge clock) begin
      if (en) begin
         dp_ff <= 61'(zc) * 61'(DIST_SCALE);
      end
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_distance_ff <= dp_r[22:0];
      end
   end

   // transaction valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ST_DP; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff[0] <= req_valid;
            for (int k = 1; k <= ST_DP; k++) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= vld_ff[ST_DP];
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for haversine_distance.
// Point pairs go in through the req channel with random gaps. Each accepted
// transaction is run through a bit-exact fixed-point model of the cordic and
// square root datapath. The rsp channel sees random stalls, and every result
// is checked in order against the modeled distance.
// ----------------------------------------------------------------------------
module tb;

   localparam int NUM_RANDOM = 1950;
   localparam longint TURN    = 47185920;
   localparam longint QUARTER = 11796480;
   localparam longint INV_G   = 652032874;
   localparam longint ONE30   = 64'sd1 << 30;
   localparam longint ONE60   = 64'sd1 << 60;
   localparam longint HALFPI  = 1686629713;
   localparam longint DEG_RAD = 74961321;
   localparam longint DSCALE  = 835061023;

   typedef struct {
      logic signed [23:0] lat_a;
      logic signed [24:0] lon_a;
      logic signed [23:0] lat_b;
      logic signed [24:0] lon_b;
   } point_pair_type;

   function automatic longint step_ang(int i);
      longint tab [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return tab[i];
      return 64'sd1 << (30 - i);
   endfunction

   // angle in degrees with 17 fraction bits, returns cos and sin q30
   function automatic void rotate_angle(input longint a17, output longint c,
                                        output longint s);
      longint a, q, r, z, x, y, dx, dy;
      a = a17 % TURN;
      if (a < 0) a += TURN;
      q = a / QUARTER;
      r = a - q * QUARTER;
      z = (r * DEG_RAD + (64'sd1 << 18)) >>> 19;
      x = INV_G;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= step_ang(i);
         end else begin
            x += dx; y -= dy; z += step_ang(i);
         end
      end
      x = x < 0 ? 0 : (x > ONE30 ? ONE30 : x);
      y = y < 0 ? 0 : (y > ONE30 ? ONE30 : y);
      case (q)
         0: begin c = x;  s = y;  end
         1: begin c = -y; s = x;  end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint floor_sqrt(longint n);
      longint res, b;
      res = 0;
      b = 64'sd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [22:0] great_circle_distance(point_pair_type p);
      longint la, oa, lb, ob, c1, s1, c2, s2, ca, sa, cb, sb;
      longint m1, m2, ua, ub, h, xs, ys, z, dx, dy;
      logic [127:0] d;
      la = p.lat_a; oa = p.lon_a; lb = p.lat_b; ob = p.lon_b;
      rotate_angle(lb - la, c1, s1);
      rotate_angle(ob - oa, c2, s2);
      rotate_angle(la * 2, ca, sa);
      rotate_angle(lb * 2, cb, sb);
      m1 = s1 < 0 ? -s1 : s1;
      m2 = s2 < 0 ? -s2 : s2;
      ua = ((ca < 0 ? -ca : ca) * m2 + (64'sd1 << 29)) >>> 30;
      ub = ((cb < 0 ? -cb : cb) * m2 + (64'sd1 << 29)) >>> 30;
      h = ((ca < 0) != (cb < 0)) ? m1 * m1 - ua * ub : m1 * m1 + ua * ub;
      h = h < 0 ? 0 : (h > ONE60 ? ONE60 : h);
      ys = floor_sqrt(h);
      xs = floor_sqrt(ONE60 - h);
      z = 0;
      for (int i = 0; i < 30; i++) begin
         dx = ys >>> i;
         dy = xs >>> i;
         if (ys > 0) begin
            xs += dx; ys -= dy; z += step_ang(i);
         end else begin
            xs -= dx; ys += dy; z -= step_ang(i);
         end
      end
      z = z < 0 ? 0 : (z > HALFPI ? HALFPI : z);
      d = (128'(z) * 128'(DSCALE) + (128'd1 << 37)) >> 38;
      return d[22:0];
   endfunction

   class distance_scoreboard;
      logic [22:0] pending_q[$];
      int mismatches;
      int checked;

      function void note_pair(point_pair_type p);
         pending_q.push_back(great_circle_distance(p));
      endfunction

      function void check_distance(logic [22:0] got);
         logic [22:0] want;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result distance=%0d", got);
            return;
         end
         want = pending_q.pop_front();
         checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("distance mismatch: expected %0d got %0d", want, got);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_lat_a = '0;
   logic signed [24:0] req_lon_a = '0;
   logic signed [23:0] req_lat_b = '0;
   logic signed [24:0] req_lon_b = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic        [22:0] rsp_distance;

   distance_scoreboard sb = new();
   int  pairs_sent;
   bit  stim_done;
   bit  rsp_burst;

   always #10 clock = ~clock;

   haversine_distance dut (.*);

   task automatic send_pair(point_pair_type p, bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lat_a <= p.lat_a;
      req_lon_a <= p.lon_a;
      req_lat_b <= p.lat_b;
      req_lon_b <= p.lon_b;
      do @(posedge clock); while (!req_ready);
      sb.note_pair(p);
      pairs_sent++;
   endtask

   function automatic point_pair_type mk(longint a, longint b, longint c, longint d);
      point_pair_type p;
      p.lat_a = 24'(a); p.lon_a = 25'(b); p.lat_b = 24'(c); p.lon_b = 25'(d);
      return p;
   endfunction

   function automatic point_pair_type random_pair();
      point_pair_type p;
      case ($urandom_range(0, 3))
         0: begin
            // raw bit patterns, also beyond the legal angle ranges
            p.lat_a = 24'($urandom); p.lon_a = 25'($urandom);
            p.lat_b = 24'($urandom); p.lon_b = 25'($urandom);
         end
         1: begin
            // nearby points
            p.lat_a = 24'($signed($urandom_range(0, 11796480)) - 5898240);
            p.lon_a = 25'($signed($urandom_range(0, 23592960)) - 11796480);
            p.lat_b = 24'(p.lat_a + ($signed($urandom_range(0, 2000)) - 1000));
            p.lon_b = 25'(p.lon_a + ($signed($urandom_range(0, 2000)) - 1000));
         end
         default: begin
            p.lat_a = 24'($signed($urandom_range(0, 11796480)) - 5898240);
            p.lon_a = 25'($signed($urandom_range(0, 23592960)) - 11796480);
            p.lat_b = 24'($signed($urandom_range(0, 11796480)) - 5898240);
            p.lon_b = 25'($signed($urandom_range(0, 23592960)) - 11796480);
         end
      endcase
      return p;
   endfunction

   // result side: random stalls with occasional full-speed stretches
   initial begin
      int wait_n;
      repeat (7) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_burst = ~rsp_burst;
         wait_n = rsp_burst ? 0 : $urandom_range(0, 10);
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_distance(rsp_distance);
   end

   initial begin
      point_pair_type directed [$];
      bit burst;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed = '{
         mk(0, 0, 0, 0),
         mk(5898240, 0, -5898240, 0),
         mk(-5898240, 11796480, 5898240, -11796480),
         mk(0, -11796480, 0, 11796480),
         mk(0, 0, 0, 11796480),
         mk(0, 0, 0, -11796480),
         mk(5898240, 100, 5898240, -100),
         mk(0, 0, 1, 1),
         mk(0, 0, 0, 5898240),
         mk(2949120, 0, -2949120, 11796480),
         mk(-8388608, -16777216, 8388607, 16777215),
         mk(8388607, 16777215, -8388608, -16777216),
         mk(-1, -1, 0, 0),
         mk(3342336, 884736, 3342336, 884737),
         mk(5898239, 0, -5898239, 11796479),
         mk(1000000, -5000000, -2000000, 7000000)
      };
      foreach (directed[i]) send_pair(directed[i], 1'b0);
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if ($urandom_range(0, 20) == 0) burst = ~burst;
         send_pair(random_pair(), burst);
      end
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      $display("sent %0d point pairs, %0d distances checked, %0d mismatches",
               pairs_sent, sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

endmodule
